// ===== rtl/ultrasonic_range_sequencer_assert.svh =====
// Assertion macros shared by the range sequencer RTL.
`ifndef ULTRASONIC_RANGE_SEQUENCER_ASSERT_SVH
`define ULTRASONIC_RANGE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("range sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define URS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("range sequencer check failed");

`endif

// ===== rtl/ursq_pkg.sv =====
// Shared types, codes and constants of the ultrasonic range sequencer.
package ursq_pkg;

	localparam int WAIT_W    = 20;
	localparam int DIVISOR_W = 10;
	localparam int TRIG_W    = 8;
	localparam int DIST_W    = 24;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 80;

	// measurement phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_TRIG   = 3'd1;
	localparam logic [2:0] PH_WAIT   = 3'd2;
	localparam logic [2:0] PH_HIGH   = 3'd3;
	localparam logic [2:0] PH_SETTLE = 3'd4;

	// sequencer states
	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_DIV_CM   = 2'd1;
	localparam logic [1:0] ST_DIV_INCH = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_NONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_IN      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_OUT     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_TIMEOUT = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_WAIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CM_DIV    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCH_DIV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG      = 3'd5;

	// register reset values
	localparam logic [WAIT_W-1:0]    RST_ECHO_WAIT = 20'd30000;
	localparam logic [DIVISOR_W-1:0] RST_CM_DIV    = 10'd58;
	localparam logic [DIVISOR_W-1:0] RST_INCH_DIV  = 10'd148;
	localparam logic [WAIT_W-1:0]    RST_MAX_PULSE = 20'd23200;
	localparam logic [WAIT_W-1:0]    RST_SETTLE    = 20'd60000;
	localparam logic [TRIG_W-1:0]    RST_TRIG      = 8'd10;

	localparam logic [WAIT_W-1:0] MASK20 = 20'hFFFFF;
	localparam logic [DIST_W-1:0] MASK24 = 24'hFFFFFF;

	typedef struct packed {
		logic                 start;
		logic [DIVISOR_W-1:0] divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/ursq_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
`include "ultrasonic_range_sequencer_assert.svh"

module ursq_divider import ursq_pkg::*; #(
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  div_ctrl_t     ctrl,
	input  logic [DW-1:0] dividend,
	output div_stat_t     stat,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]        work_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	assign trial = {rem_q, work_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !ctrl.start && busy_q && (cnt_q == CNT_W'(1));
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= ctrl.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DW-2:0], fits};
			rem_q  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = work_q;

	`URS_ASSERT_IMP(a_start_idle, clk, arst_n, ctrl.start, !busy_q)
	`URS_ASSERT_IMP(a_cnt_busy, clk, arst_n, busy_q, cnt_q != '0)
	`URS_ASSERT_NXT(a_done_single, clk, arst_n, done_q, !done_q)

endmodule

// ===== rtl/ultrasonic_range_sequencer.sv =====
// Top level: tick sequencer for trigger/echo ranging with a shared serial divider.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   s_axis_tdata: one tick word
//   m_axis    out  m_axis_tvalid/m_axis_tready   m_axis_tdata: one result word
//   cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A plain tick loads its result word as it is taken, except the tick on which
// echo falls: it runs the shared divider for the cm and then the inch quotient,
// and its result word is loaded when the inch quotient is done; no tick is
// taken until then. A new tick is taken once the result word of the previous
// one is gone or leaves in the same cycle. Reset is asynchronous and restores
// the register defaults; a stalled m_axis holds off s_axis.
`include "ultrasonic_range_sequencer_assert.svh"

module ultrasonic_range_sequencer import ursq_pkg::*; #(
	parameter int COUNT_WIDTH = 20,
	parameter int FRAC_BITS   = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [0] start_req, [1] echo_level, [2] settle_after, [7:3] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] trigger_level, [1] busy_res, [2] done_res, [4:3] status,
	// [24:5] echo_width, [48:25] distance_cm, [72:49] distance_inch, [79:73] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int QW     = COUNT_WIDTH + FRAC_BITS;
	localparam int WW     = (COUNT_WIDTH > WAIT_W) ? COUNT_WIDTH : WAIT_W;
	localparam int QSAT_W = (QW > DIST_W) ? QW : DIST_W;

	// configuration
	logic [WAIT_W-1:0]    echo_wait_q, max_pulse_q, settle_ticks_q;
	logic [DIVISOR_W-1:0] cm_div_q, inch_div_q;
	logic [TRIG_W-1:0]    trig_ticks_q;

	// tick state
	logic [2:0]             phase_q;
	logic [WAIT_W-1:0]      timer_q;
	logic [COUNT_WIDTH-1:0] pulse_q;
	logic                   settle_q;
	logic [STATUS_W-1:0]    status_q;
	logic [WAIT_W-1:0]      width_q;
	logic [DIST_W-1:0]      cm_q, inch_q;
	logic                   trig_q, busy_q, done_q;

	// sequencer
	logic [1:0] st_q;
	logic       mvalid_q;
	logic       word_set;

	logic start_req, echo_level, settle_after;
	logic in_acc, out_free;

	logic [2:0]             nx_phase;
	logic [WAIT_W-1:0]      nx_timer, timer_inc;
	logic [COUNT_WIDTH-1:0] nx_pulse;
	logic                   nx_settle;
	logic [STATUS_W-1:0]    nx_status;
	logic [WAIT_W-1:0]      nx_width;
	logic                   t_trig, t_busy, t_done, t_fall;
	logic [2:0]             finish_phase;
	logic [WW-1:0]          pulse_wide;

	div_ctrl_t      div_ctrl;
	div_stat_t      div_stat;
	logic [QW-1:0]  quot;
	logic [QSAT_W-1:0] quot_wide;
	logic           quot_big;

	assign start_req    = s_axis_tdata[0];
	assign echo_level   = s_axis_tdata[1];
	assign settle_after = s_axis_tdata[2];

	assign out_free      = !mvalid_q || m_axis_tready;
	assign s_axis_tready = (st_q == ST_IDLE) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign timer_inc    = (timer_q != MASK20) ? timer_q + 1'b1 : timer_q;
	assign finish_phase = (settle_q && settle_ticks_q != '0) ? PH_SETTLE : PH_IDLE;
	assign pulse_wide   = WW'(pulse_q);

	always_comb begin
		nx_phase  = phase_q;
		nx_timer  = timer_q;
		nx_pulse  = pulse_q;
		nx_settle = settle_q;
		nx_status = status_q;
		nx_width  = width_q;
		t_trig    = 1'b0;
		t_busy    = 1'b1;
		t_done    = 1'b0;
		t_fall    = 1'b0;
		unique case (phase_q)
			PH_TRIG: begin
				if (timer_q >= WAIT_W'(trig_ticks_q)) begin
					nx_phase = PH_WAIT;
					nx_timer = '0;
				end else begin
					t_trig   = 1'b1;
					nx_timer = timer_q + 1'b1;
				end
			end
			PH_WAIT: begin
				if (echo_level) begin
					nx_phase = PH_HIGH;
					nx_pulse = COUNT_WIDTH'(1);
				end else begin
					nx_timer = timer_inc;
					if (timer_inc >= echo_wait_q) begin
						nx_status = STAT_TIMEOUT;
						t_done    = 1'b1;
						nx_timer  = '0;
						nx_phase  = finish_phase;
					end
				end
			end
			PH_HIGH: begin
				if (echo_level) begin
					if (pulse_q != '1)
						nx_pulse = pulse_q + 1'b1;
				end else begin
					nx_width  = (pulse_wide > WW'(MASK20)) ? MASK20 : pulse_wide[WAIT_W-1:0];
					nx_status = (pulse_wide > WW'(max_pulse_q)) ? STAT_OUT : STAT_IN;
					t_done    = 1'b1;
					t_fall    = 1'b1;
					nx_timer  = '0;
					nx_phase  = finish_phase;
				end
			end
			PH_SETTLE: begin
				nx_timer = timer_inc;
				if (timer_inc >= settle_ticks_q) begin
					nx_phase = PH_IDLE;
					nx_timer = '0;
				end
			end
			default: begin
				nx_phase = PH_IDLE;
				if (start_req) begin
					nx_phase  = PH_TRIG;
					nx_settle = settle_after;
					t_trig    = 1'b1;
					nx_timer  = WAIT_W'(1);
					nx_pulse  = '0;
				end else begin
					t_busy = 1'b0;
				end
			end
		endcase
	end

	// cm quotient starts on the falling-echo tick, inch right after cm is done
	always_comb begin
		div_ctrl.start   = 1'b0;
		div_ctrl.divisor = cm_div_q;
		if (in_acc && t_fall) begin
			div_ctrl.start = 1'b1;
		end else if (st_q == ST_DIV_CM && div_stat.done) begin
			div_ctrl.start   = 1'b1;
			div_ctrl.divisor = inch_div_q;
		end
	end

	assign quot_wide = QSAT_W'(quot);
	assign quot_big  = quot_wide > QSAT_W'(MASK24);

	ursq_divider #(
		.DW(QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (QW'(pulse_q) << FRAC_BITS),
		.stat     (div_stat),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_wait_q    <= RST_ECHO_WAIT;
			cm_div_q       <= RST_CM_DIV;
			inch_div_q     <= RST_INCH_DIV;
			max_pulse_q    <= RST_MAX_PULSE;
			settle_ticks_q <= RST_SETTLE;
			trig_ticks_q   <= RST_TRIG;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ECHO_WAIT: echo_wait_q    <= cfg_data[WAIT_W-1:0];
				REG_CM_DIV:    cm_div_q       <= cfg_data[DIVISOR_W-1:0];
				REG_INCH_DIV:  inch_div_q     <= cfg_data[DIVISOR_W-1:0];
				REG_MAX_PULSE: max_pulse_q    <= cfg_data[WAIT_W-1:0];
				REG_SETTLE:    settle_ticks_q <= cfg_data[WAIT_W-1:0];
				REG_TRIG:      trig_ticks_q   <= cfg_data[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			timer_q  <= '0;
			pulse_q  <= '0;
			settle_q <= 1'b0;
			status_q <= STAT_NONE;
			width_q  <= '0;
			cm_q     <= '0;
			inch_q   <= '0;
			trig_q   <= 1'b0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			st_q     <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_DIV_CM: begin
					if (div_stat.done) begin
						cm_q <= (cm_div_q == '0 || quot_big) ? MASK24 : quot_wide[DIST_W-1:0];
						st_q <= ST_DIV_INCH;
					end
				end
				ST_DIV_INCH: begin
					if (div_stat.done) begin
						inch_q   <= (inch_div_q == '0 || quot_big) ? MASK24
						            : quot_wide[DIST_W-1:0];
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					if (in_acc) begin
						phase_q  <= nx_phase;
						timer_q  <= nx_timer;
						pulse_q  <= nx_pulse;
						settle_q <= nx_settle;
						status_q <= nx_status;
						width_q  <= nx_width;
						trig_q   <= t_trig;
						busy_q   <= t_busy;
						done_q   <= t_done;
						if (t_fall)
							st_q <= ST_DIV_CM;
					end
				end
			endcase
		end
	end

	// result word is loaded by a plain tick or by the end of the inch quotient
	assign word_set = (in_acc && !t_fall) || (st_q == ST_DIV_INCH && div_stat.done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mvalid_q <= 1'b0;
		else if (word_set)
			mvalid_q <= 1'b1;
		else if (m_axis_tready)
			mvalid_q <= 1'b0;
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = {7'b0, inch_q, cm_q, width_q, status_q, done_q, busy_q, trig_q};

	`URS_ASSERT_IMP(a_no_take_in_div, clk, arst_n, st_q != ST_IDLE, !s_axis_tready)
	`URS_ASSERT_NXT(a_cm_then_inch, clk, arst_n, st_q == ST_DIV_CM && div_stat.done,
		st_q == ST_DIV_INCH)
	`URS_ASSERT_NXT(a_word_held, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

endmodule

// ===== sim/ultrasonic_range_sequencer_tb.sv =====
// Self-checking testbench for the ultrasonic range sequencer: tick stream in, result words out.
module ultrasonic_range_sequencer_tb import ursq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC        = 4;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RAND_TICKS  = 1850;
	localparam int PHASE_TICKS = 150;

	typedef struct packed {
		logic [6:0]          pad;
		logic [DIST_W-1:0]   inch;
		logic [DIST_W-1:0]   cm;
		logic [WAIT_W-1:0]   width;
		logic [STATUS_W-1:0] status;
		logic                done;
		logic                busy;
		logic                trig;
	} range_word_t;

	typedef struct packed {
		logic        has;
		range_word_t w;
	} typed_word_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [2:0]            bits;
		logic                  has;
		range_word_t           w;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ECHO_WAIT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ultrasonic_range_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predictor copy of the registers and the tick state
	logic [WAIT_W-1:0]    r_wait   = RST_ECHO_WAIT;
	logic [DIVISOR_W-1:0] r_cm     = RST_CM_DIV;
	logic [DIVISOR_W-1:0] r_inch   = RST_INCH_DIV;
	logic [WAIT_W-1:0]    r_max    = RST_MAX_PULSE;
	logic [WAIT_W-1:0]    r_settle = RST_SETTLE;
	logic [TRIG_W-1:0]    r_trig   = RST_TRIG;
	logic [2:0]           ph       = PH_IDLE;
	logic [WAIT_W-1:0]    ph_timer = '0;
	logic [WAIT_W-1:0]    pulse_cnt = '0;
	logic                 settle_f = 1'b0;
	logic [WAIT_W-1:0]    last_width = '0;
	logic [DIST_W-1:0]    last_cm = '0;
	logic [DIST_W-1:0]    last_inch = '0;
	logic [STATUS_W-1:0]  last_status = STAT_NONE;

	range_word_t pending_words [$];
	typed_word_t typed_words [$];
	dir_row_t    dir_rows [$];

	int cycle_count = 0;
	int errors = 0;
	int ticks_sent = 0;
	int words_checked = 0;
	int n_in_range = 0, n_out_range = 0, n_timeout = 0;
	int phases = 0;
	int stall_left = 0, hold_left = 0;
	bit pressure_done = 1'b0;

	// stimulus plan of the current register setting
	int   plan_wait, plan_cm, plan_inch, plan_max, plan_settle, plan_trig;
	logic plan_allow_settle = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic range_word_t mk_word(logic trig, logic busy, logic done,
			logic [STATUS_W-1:0] status, logic [WAIT_W-1:0] width,
			logic [DIST_W-1:0] cm, logic [DIST_W-1:0] inch);
		range_word_t w;
		w = '0;
		w.trig = trig;
		w.busy = busy;
		w.done = done;
		w.status = status;
		w.width = width;
		w.cm = cm;
		w.inch = inch;
		return w;
	endfunction

	function automatic logic [DIST_W-1:0] scaled_quotient(logic [WAIT_W-1:0] w,
			logic [DIVISOR_W-1:0] d);
		logic [63:0] q;
		if (d == '0)
			return MASK24;
		q = ({44'd0, w} << FRAC) / {54'd0, d};
		return (q > {40'd0, MASK24}) ? MASK24 : q[DIST_W-1:0];
	endfunction

	task automatic close_measurement();
		ph_timer = '0;
		if (settle_f && r_settle != '0)
			ph = PH_SETTLE;
		else
			ph = PH_IDLE;
	endtask

	task automatic predict_tick(input logic start, input logic echo, input logic settle,
			output range_word_t r);
		r = '0;
		r.busy = 1'b1;
		case (ph)
			PH_TRIG: begin
				if (ph_timer >= {12'd0, r_trig}) begin
					ph = PH_WAIT;
					ph_timer = '0;
				end else begin
					r.trig = 1'b1;
					ph_timer = ph_timer + 1'b1;
				end
			end
			PH_WAIT: begin
				if (echo) begin
					ph = PH_HIGH;
					pulse_cnt = WAIT_W'(1);
				end else begin
					if (ph_timer < MASK20)
						ph_timer = ph_timer + 1'b1;
					if (ph_timer >= r_wait) begin
						last_status = STAT_TIMEOUT;
						r.done = 1'b1;
						close_measurement();
					end
				end
			end
			PH_HIGH: begin
				if (echo) begin
					// counter is as wide as the reported width, so it saturates there
					if (pulse_cnt < MASK20)
						pulse_cnt = pulse_cnt + 1'b1;
				end else begin
					last_width = pulse_cnt;
					last_cm = scaled_quotient(pulse_cnt, r_cm);
					last_inch = scaled_quotient(pulse_cnt, r_inch);
					last_status = (pulse_cnt > r_max) ? STAT_OUT : STAT_IN;
					r.done = 1'b1;
					close_measurement();
				end
			end
			PH_SETTLE: begin
				if (ph_timer < MASK20)
					ph_timer = ph_timer + 1'b1;
				if (ph_timer >= r_settle) begin
					ph = PH_IDLE;
					ph_timer = '0;
				end
			end
			default: begin
				ph = PH_IDLE;
				if (start) begin
					ph = PH_TRIG;
					settle_f = settle;
					r.trig = 1'b1;
					ph_timer = WAIT_W'(1);
					pulse_cnt = '0;
				end else begin
					r.busy = 1'b0;
				end
			end
		endcase
		r.status = last_status;
		r.width = last_width;
		r.cm = last_cm;
		r.inch = last_inch;
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_ECHO_WAIT: r_wait = d;
			REG_CM_DIV:    r_cm = d[DIVISOR_W-1:0];
			REG_INCH_DIV:  r_inch = d[DIVISOR_W-1:0];
			REG_MAX_PULSE: r_max = d;
			REG_SETTLE:    r_settle = d;
			REG_TRIG:      r_trig = d[TRIG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [DIST_W-1:0] want,
			input logic [DIST_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// scoreboard: predict on every accepted tick word, compare every result word
	always @(posedge clk) begin : monitor
		range_word_t got, want;
		typed_word_t tw;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				words_checked++;
				if (pending_words.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result word, expected none, actual %0h",
						$time, got);
				end else begin
					want = pending_words.pop_front();
					check_field("trigger_level", DIST_W'(want.trig), DIST_W'(got.trig));
					check_field("busy_res", DIST_W'(want.busy), DIST_W'(got.busy));
					check_field("done_res", DIST_W'(want.done), DIST_W'(got.done));
					check_field("status", DIST_W'(want.status), DIST_W'(got.status));
					check_field("echo_width", DIST_W'(want.width), DIST_W'(got.width));
					check_field("distance_cm", want.cm, got.cm);
					check_field("distance_inch", want.inch, got.inch);
					check_field("pad", DIST_W'(want.pad), DIST_W'(got.pad));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_tick(s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2], want);
				tw = typed_words.pop_front();
				if (tw.has)
					want = tw.w;
				pending_words.push_back(want);
				if (want.done) begin
					if (want.status == STAT_IN)
						n_in_range++;
					else if (want.status == STAT_OUT)
						n_out_range++;
					else
						n_timeout++;
				end
			end
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		// every fourth stretch of cycles runs without any idling
		if (((cycle_count / 3000) % 4) == 3)
			return 0;
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side: random stalls plus one long hold-off to back up the block
	always @(posedge clk) begin : receiver
		int n;
		if (!pressure_done && words_checked >= 600) begin
			hold_left = 400;
			pressure_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			n = idle_len();
			if (n == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				stall_left = n - 1;
			end
		end
	end

	task automatic send_tick(input logic [2:0] bits, input logic has, input range_word_t w);
		int gap;
		typed_word_t tw;
		gap = idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tw.has = has;
		tw.w = w;
		typed_words.push_back(tw);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, bits};
		do @(posedge clk); while (!s_axis_tready);
		ticks_sent++;
	endtask

	task automatic send_bits(input logic [2:0] bits);
		send_tick(bits, 1'b0, '0);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (words_checked < ticks_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic add_tick(input logic start, input logic echo, input logic settle,
			input logic has, input range_word_t w);
		dir_row_t row;
		row = '0;
		row.kind = ROW_TICK;
		row.bits = {settle, echo, start};
		row.has = has;
		row.w = w;
		dir_rows.push_back(row);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = d;
		dir_rows.push_back(row);
	endtask

	// busy-phase word: start mostly low, settle bit only where the plan allows it
	function automatic logic [2:0] noise_bits(input logic echo);
		logic s, t;
		s = logic'($urandom_range(0, 1));
		t = ($urandom_range(0, 9) == 0);
		return {s & plan_allow_settle, echo, t};
	endfunction

	// one measurement with random content, or now and then a few arbitrary words
	task automatic measure_burst();
		int n, w, h;
		logic se, e;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 10);
			repeat (n) begin
				e = logic'($urandom_range(0, 1));
				se = logic'($urandom_range(0, 1));
				send_bits({se & plan_allow_settle, e, logic'($urandom_range(0, 1))});
			end
			return;
		end
		se = logic'($urandom_range(0, 1));
		se = se & plan_allow_settle;
		e = logic'($urandom_range(0, 1));
		send_bits({se, e, 1'b1});
		repeat ((plan_trig == 0) ? 1 : plan_trig) begin
			e = logic'($urandom_range(0, 1));
			send_bits(noise_bits(e));
		end
		if (plan_wait <= 60 && $urandom_range(0, 3) == 0) begin
			repeat (plan_wait + 1) send_bits(noise_bits(1'b0));
		end else begin
			w = (plan_wait == 0) ? 0 : $urandom_range(0, ((plan_wait < 40) ? plan_wait : 40) - 1);
			repeat (w) send_bits(noise_bits(1'b0));
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 300) : $urandom_range(1, 30);
			repeat (h) send_bits(noise_bits(1'b1));
			send_bits(noise_bits(1'b0));
		end
		if (se) begin
			repeat (plan_settle) begin
				e = logic'($urandom_range(0, 1));
				send_bits(noise_bits(e));
			end
		end
		n = $urandom_range(0, 3);
		repeat (n) begin
			e = logic'($urandom_range(0, 1));
			send_bits({noise_bits(e) & 3'b110});
		end
	endtask

	task automatic pick_plan(input int p);
		case (p)
			0: begin
				plan_trig = 1; plan_wait = 1048575; plan_cm = 1; plan_inch = 1;
				plan_max = 1048575; plan_settle = 0;
			end
			1: begin
				plan_trig = 255; plan_wait = 1; plan_cm = 1023; plan_inch = 1023;
				plan_max = 0; plan_settle = 1048575;
			end
			2: begin
				// divisor 1024 keeps only its low bits: a zero divisor
				plan_trig = 0; plan_wait = 0; plan_cm = 1024; plan_inch = 1;
				plan_max = 1; plan_settle = 1;
			end
			default: begin
				plan_trig = $urandom_range(1, 6);
				plan_wait = $urandom_range(1, 40);
				plan_cm = $urandom_range(1, 1023);
				plan_inch = $urandom_range(1, 1023);
				plan_max = $urandom_range(0, 60);
				plan_settle = $urandom_range(0, 12);
			end
		endcase
		plan_allow_settle = (plan_settle < 64);
	endtask

	initial begin : stimulus
		bit cfg_open;
		int p, phase_start;
		dir_row_t row;

		// directed rows, reset settings first
		add_tick(1'b0, 1'b0, 1'b0, 1'b1, '0);
		add_tick(1'b0, 1'b1, 1'b1, 1'b1, '0);
		add_cfg(REG_TRIG, 20'd256);
		add_cfg(REG_ECHO_WAIT, 20'd0);
		add_tick(1'b1, 1'b0, 1'b0, 1'b1, mk_word(1'b1, 1'b1, 1'b0, STAT_NONE, '0, '0, '0));
		add_tick(1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, 1'b0, 1'b1,
			mk_word(1'b0, 1'b1, 1'b1, STAT_TIMEOUT, '0, '0, '0));
		add_tick(1'b0, 1'b0, 1'b0, 1'b1,
			mk_word(1'b0, 1'b0, 1'b0, STAT_TIMEOUT, '0, '0, '0));
		add_cfg(REG_CM_DIV, 20'd1024);
		add_cfg(REG_INCH_DIV, 20'd1023);
		add_cfg(REG_MAX_PULSE, 20'd0);
		add_cfg(REG_ECHO_WAIT, 20'd5);
		add_cfg(REG_SETTLE, 20'd0);
		add_tick(1'b1, 1'b0, 1'b1, 1'b0, '0);
		add_tick(1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b1, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b1, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, 1'b0, 1'b1,
			mk_word(1'b0, 1'b1, 1'b1, STAT_OUT, 20'd2, MASK24, '0));
		add_tick(1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_cfg(REG_SETTLE, 20'd3);
		add_cfg(REG_TRIG, 20'd2);
		add_tick(1'b1, 1'b0, 1'b1, 1'b0, '0);
		add_tick(1'b1, 1'b1, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b1, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b1, 1'b1, 1'b0, '0);
		add_tick(1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_tick(1'b1, 1'b0, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, 1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, 1'b0, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_open = 1'b0;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				if (!cfg_open)
					drain();
				write_reg(row.idx, row.data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open)
					cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				send_tick(row.bits, row.has, row.w);
			end
		end

		p = 0;
		phase_start = ticks_sent;
		while (ticks_sent - phase_start < RAND_TICKS) begin
			drain();
			pick_plan(p);
			write_reg(REG_ECHO_WAIT, CFG_DATA_W'(plan_wait));
			write_reg(REG_CM_DIV, CFG_DATA_W'(plan_cm));
			write_reg(REG_INCH_DIV, CFG_DATA_W'(plan_inch));
			write_reg(REG_MAX_PULSE, CFG_DATA_W'(plan_max));
			write_reg(REG_SETTLE, CFG_DATA_W'(plan_settle));
			write_reg(REG_TRIG, CFG_DATA_W'(plan_trig));
			cfg_valid <= 1'b0;
			phases++;
			begin : one_setting
				int base;
				base = ticks_sent;
				while (ticks_sent - base < PHASE_TICKS && ticks_sent - phase_start < RAND_TICKS)
					measure_burst();
			end
			p++;
		end

		drain();
		repeat (60) @(posedge clk);
		if (pending_words.size() != 0) begin
			errors++;
			$display("%0t ns: %0d result words never arrived", $time, pending_words.size());
		end
		$display("Ran %0d tick words across %0d random register settings after the directed rows.",
			ticks_sent, phases);
		$display("Measurements seen: %0d in range, %0d out of range, %0d echo timeouts.",
			n_in_range, n_out_range, n_timeout);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
